// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the stack block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/swrs_pkg.sv -----
// package: types and constants of the stack block
`default_nettype none

package swrs_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int SUM_W       = DATA_W + ADDR_W;
    localparam int ENTRY_W     = 7;

    typedef enum logic [1:0] {
        MODE_PUSH     = 2'd0,
        MODE_POP      = 2'd1,
        MODE_REVERSE  = 2'd2,
        MODE_DESCRIBE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_WAIT,
        S_REV_RD_LO,
        S_REV_RD_HI,
        S_REV_WR_LO,
        S_REV_WR_HI,
        S_DESC_RD,
        S_DESC_ACC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [DATA_W-1:0] push_value;
    } req_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic signed [DATA_W-1:0] smallest;
        logic signed [DATA_W-1:0] largest;
        logic signed [DATA_W-1:0] mean_value;
        logic [ENTRY_W-1:0]       entry_count;
        status_t                  status;
    } rsp_item_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/swrs_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module swrs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/swrs_divider.sv -----
// iterative signed-by-unsigned divider, one quotient bit per cycle
`default_nettype none

module swrs_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire swrs_pkg::div_req_t req,
    output swrs_pkg::div_rsp_t      rsp
);

    import swrs_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg, den_next;

    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_sub;
    logic              fits;
    logic [SUM_W-1:0]  q_signed;

    assign rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            // work on the magnitude, fix the sign at the end
            neg_next  = req.dividend[SUM_W-1];
            quo_next  = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
            rem_next  = '0;
            den_next  = req.divisor;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            rem_next  = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // truncation toward zero: negate the magnitude quotient
    assign q_signed     = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = signed'(q_signed[DATA_W-1:0]);

endmodule

`default_nettype wire

// ----- rtl/core/stack_with_reverse_and_stats.sv -----
// Bounded LIFO stack of signed 32-bit values with push, pop, in-place reverse and a
// describe request that returns min, max and the mean truncated toward zero. Every
// accepted item gives exactly one result with the count held afterwards. One item is
// worked on at a time and the values live in a single-write, single-read RAM, so its
// port sets the pace: pop waits for the registered read, reverse does one read, read,
// write, write per swapped pair, and describe reads and accumulates each held value in
// turn through one compare and add unit, then runs the bit-serial divider (SUM_W = 38
// at depth 64). A result waits in an output register; a new item is taken while it
// waits.
`default_nettype none
`include "assert_macros.svh"

module stack_with_reverse_and_stats (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire swrs_pkg::req_item_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output swrs_pkg::rsp_item_t      rsp
);

    import swrs_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    rsp_item_t                res_reg, res_next;
    rsp_item_t                out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]        lo_reg, lo_next;
    logic [ADDR_W-1:0]        hi_reg, hi_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [DATA_W-1:0]        tmp_reg, tmp_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [DATA_W-1:0] max_reg, max_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic [CNT_W-1:0]         cnt_m1;
    logic                     out_free;
    logic signed [DATA_W-1:0] rd_val;
    logic [ADDR_W-1:0]        lo_inc;
    logic [ADDR_W-1:0]        hi_dec;

    swrs_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    swrs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cnt_m1   = cnt_reg - 1'b1;
    assign out_free = !out_valid_reg || !rsp_stall;
    assign rd_val   = signed'(ram_rdata);
    assign lo_inc   = lo_reg + 1'b1;
    assign hi_dec   = hi_reg - 1'b1;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        tmp_next       = tmp_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[ADDR_W-1:0];
        ram_wdata      = req.push_value;
        ram_re         = 1'b0;
        ram_raddr      = cnt_m1[ADDR_W-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = sum_reg;
        div_req.divisor  = cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next   = '0;
                    state_next = S_EMIT;
                    case (req.mode)
                        MODE_PUSH:
                        begin
                            if (cnt_reg >= CNT_W'(STACK_DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        MODE_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                cnt_next   = cnt_m1;
                                state_next = S_POP_WAIT;
                            end
                        end
                        MODE_REVERSE:
                        begin
                            if (cnt_reg > CNT_W'(1))
                            begin
                                lo_next    = '0;
                                hi_next    = cnt_m1[ADDR_W-1:0];
                                state_next = S_REV_RD_LO;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DESC_RD;
                            end
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                res_next.popped_value = rd_val;
                state_next            = S_EMIT;
            end
            S_REV_RD_LO:
            begin
                ram_re     = 1'b1;
                ram_raddr  = lo_reg;
                state_next = S_REV_RD_HI;
            end
            S_REV_RD_HI:
            begin
                ram_re     = 1'b1;
                ram_raddr  = hi_reg;
                tmp_next   = ram_rdata;
                state_next = S_REV_WR_LO;
            end
            S_REV_WR_LO:
            begin
                // read data now holds the upper entry
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = ram_rdata;
                state_next = S_REV_WR_HI;
            end
            S_REV_WR_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = tmp_reg;
                lo_next   = lo_inc;
                hi_next   = hi_dec;
                if (lo_inc < hi_dec)
                begin
                    state_next = S_REV_RD_LO;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_DESC_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = S_DESC_ACC;
            end
            S_DESC_ACC:
            begin
                if (idx_reg == '0)
                begin
                    min_next = rd_val;
                    max_next = rd_val;
                    sum_next = SUM_W'(rd_val);
                end
                else
                begin
                    min_next = (rd_val < min_reg) ? rd_val : min_reg;
                    max_next = (rd_val > max_reg) ? rd_val : max_reg;
                    sum_next = sum_reg + SUM_W'(rd_val);
                end
                if (CNT_W'(idx_reg) == cnt_m1)
                begin
                    res_next.smallest = min_next;
                    res_next.largest  = max_next;
                    state_next        = S_DIV_GO;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DESC_RD;
                end
            end
            S_DIV_GO:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    res_next.mean_value = div_rsp.quotient;
                    state_next          = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next             = res_reg;
                    out_next.entry_count = ENTRY_W'(cnt_reg);
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        idx_reg <= idx_next;
        tmp_reg <= tmp_next;
        min_reg <= min_next;
        max_reg <= max_next;
        sum_reg <= sum_next;
    end

    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(STACK_DEPTH), "count above depth")

    `ASSERT_NEXT(a_push_grows, clk, rst_n, req_valid && !req_stall && req.mode == MODE_PUSH && cnt_reg < CNT_W'(STACK_DEPTH), cnt_reg == $past(cnt_reg) + 1'b1, "push did not grow the stack")

    `ASSERT_ALWAYS(a_full_status, clk, rst_n, !(state_reg == S_EMIT && res_reg.status == ST_FULL) || cnt_reg == CNT_W'(STACK_DEPTH), "full status with room left")

    `ASSERT_ALWAYS(a_rev_order, clk, rst_n, !(state_reg == S_REV_RD_LO || state_reg == S_REV_WR_HI) || lo_reg < hi_reg, "reverse pointers crossed")

endmodule

`default_nettype wire
